// ===== rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and helper functions shared by the SHA-256 stream hasher
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int WORD_W       = 32;
    localparam int BUF_DEPTH    = 16;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 8;
    localparam int FILL_W       = $clog2(BUF_DEPTH);
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int IDX_W        = $clog2(DIGEST_WORDS);
    localparam int LEN_W        = 64;
    localparam int CNT_W        = 3;

    localparam logic [CNT_W-1:0]  FULL_BYTES = 3'd4;
    localparam logic [WORD_W-1:0] PAD_WORD   = 32'h8000_0000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    // padding progress after the final request
    typedef enum logic [1:0] {
        PH_80,
        PH_ZERO,
        PH_LENLO,
        PH_DONE
    } t_phase;

    // commands from the sequencer to the round datapath
    typedef struct packed {
        logic                push;
        logic [WORD_W-1:0]   push_word;
        logic                load;
        logic                round;
        logic [ROUND_W-1:0]  k_idx;
        logic                update;
        logic                reset_chain;
        logic                emit;
        logic [IDX_W-1:0]    idx;
    } t_core_cmd;

    localparam logic [WORD_W-1:0] IV [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // keep the leading valid bytes of a short final word and append 0x80
    function automatic logic [WORD_W-1:0] pad_final(input logic [WORD_W-1:0] w,
                                                    input logic [CNT_W-1:0]  cnt);
        logic [WORD_W-1:0] r;
        case (cnt)
            3'd0:    r = PAD_WORD;
            3'd1:    r = {w[31:24], 24'h80_0000};
            3'd2:    r = {w[31:16], 16'h8000};
            3'd3:    r = {w[31:8], 8'h80};
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/shs_core.sv =====
// ----------------------------------------------------------------------------
// shs_core
// Block buffer / message schedule, working variables and chaining words;
// one SHA-256 round per cycle through a single shared round unit
// ----------------------------------------------------------------------------
module shs_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  shs_pkg::t_core_cmd                 i_cmd,
    output logic [shs_pkg::WORD_W-1:0]         o_digest_word
);

    localparam int W = shs_pkg::WORD_W;

    function automatic logic [W-1:0] rotr(input logic [W-1:0] v, input int s);
        return (v >> s) | (v << (W - s));
    endfunction

    logic [W-1:0] r_w     [shs_pkg::BUF_DEPTH];
    logic [W-1:0] r_v     [shs_pkg::DIGEST_WORDS];
    logic [W-1:0] r_chain [shs_pkg::DIGEST_WORDS];

    logic [W-1:0] sg0, sg1, sched_new, shift_in;
    logic [W-1:0] big0, big1, choose, major, t1, t2;

    // schedule word sixteen ahead from fixed taps of the buffer
    always_comb begin
        sg0       = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        sg1       = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        sched_new = r_w[0] + sg0 + r_w[9] + sg1;
        shift_in  = i_cmd.round ? sched_new : i_cmd.push_word;
    end

    // compression round
    always_comb begin
        big1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big1 + choose + shs_pkg::K_TABLE[i_cmd.k_idx] + r_w[0];
        big0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big0 + major;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.round) begin
            for (int i = 0; i < shs_pkg::BUF_DEPTH - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[shs_pkg::BUF_DEPTH-1] <= shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= r_chain;
        end else if (i_cmd.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_chain) begin
            r_chain <= shs_pkg::IV;
        end else if (i_cmd.update) begin
            for (int i = 0; i < shs_pkg::DIGEST_WORDS; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    assign o_digest_word = r_chain[i_cmd.idx];

endmodule

// ===== rtl/shs_ctrl.sv =====
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: takes requests, tracks fill and bit count, generates padding,
// counts rounds and steps through the digest words
// ----------------------------------------------------------------------------
module shs_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [shs_pkg::WORD_W-1:0]        i_data_word,
    input  logic [shs_pkg::CNT_W-1:0]         i_byte_count,
    input  logic                              i_final_req,
    input  logic                              i_out_free,
    output shs_pkg::t_core_cmd                o_cmd
);

    localparam logic [shs_pkg::FILL_W-1:0]  FILL_LAST  = shs_pkg::FILL_W'(shs_pkg::BUF_DEPTH - 1);
    localparam logic [shs_pkg::FILL_W-1:0]  FILL_LEN   = shs_pkg::FILL_W'(shs_pkg::BUF_DEPTH - 2);
    localparam logic [shs_pkg::ROUND_W-1:0] ROUND_LAST = shs_pkg::ROUND_W'(shs_pkg::ROUNDS - 1);
    localparam logic [shs_pkg::IDX_W-1:0]   IDX_LAST   = shs_pkg::IDX_W'(shs_pkg::DIGEST_WORDS - 1);

    shs_pkg::t_state                r_state, n_state;
    shs_pkg::t_phase                r_phase, n_phase;
    logic [shs_pkg::FILL_W-1:0]     r_fill, n_fill;
    logic [shs_pkg::LEN_W-1:0]      r_bitlen, n_bitlen;
    logic                           r_fin, n_fin;
    logic [shs_pkg::ROUND_W-1:0]    r_round, n_round;
    logic [shs_pkg::IDX_W-1:0]      r_idx, n_idx;

    logic                           accept;
    logic [shs_pkg::CNT_W-1:0]      cnt;

    assign o_ready = (r_state == shs_pkg::ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign cnt     = (i_byte_count > shs_pkg::FULL_BYTES) ? shs_pkg::FULL_BYTES : i_byte_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shs_pkg::ST_IDLE: begin
                if (accept) begin
                    if (r_fill == FILL_LAST) n_state = shs_pkg::ST_ROUND;
                    else if (i_final_req)    n_state = shs_pkg::ST_PAD;
                end
            end
            shs_pkg::ST_PAD: begin
                if (r_fill == FILL_LAST) n_state = shs_pkg::ST_ROUND;
            end
            shs_pkg::ST_ROUND: begin
                if (r_round == ROUND_LAST) n_state = shs_pkg::ST_UPDATE;
            end
            shs_pkg::ST_UPDATE: begin
                if (r_phase == shs_pkg::PH_DONE) n_state = shs_pkg::ST_EMIT;
                else if (r_fin)                  n_state = shs_pkg::ST_PAD;
                else                             n_state = shs_pkg::ST_IDLE;
            end
            shs_pkg::ST_EMIT: begin
                if (i_out_free && r_idx == IDX_LAST) n_state = shs_pkg::ST_IDLE;
            end
            default: n_state = shs_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath registers
    always_comb begin
        o_cmd    = '0;
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_bitlen = r_bitlen;
        n_fin    = r_fin;
        n_round  = r_round;
        n_idx    = r_idx;
        o_cmd.k_idx = r_round;
        o_cmd.idx   = r_idx;
        unique case (r_state)
            shs_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.push = 1'b1;
                    n_fin      = i_final_req;
                    if (i_final_req) begin
                        o_cmd.push_word = shs_pkg::pad_final(i_data_word, cnt);
                        n_bitlen = r_bitlen + {58'b0, cnt, 3'b000};
                        n_phase  = (cnt == shs_pkg::FULL_BYTES) ? shs_pkg::PH_80
                                                                : shs_pkg::PH_ZERO;
                    end else begin
                        o_cmd.push_word = i_data_word;
                        n_bitlen = r_bitlen + shs_pkg::LEN_W'(shs_pkg::WORD_W);
                    end
                end
            end
            shs_pkg::ST_PAD: begin
                o_cmd.push = 1'b1;
                unique case (r_phase)
                    shs_pkg::PH_80: begin
                        o_cmd.push_word = shs_pkg::PAD_WORD;
                        n_phase = shs_pkg::PH_ZERO;
                    end
                    shs_pkg::PH_ZERO: begin
                        if (r_fill == FILL_LEN) begin
                            o_cmd.push_word = r_bitlen[63:32];
                            n_phase = shs_pkg::PH_LENLO;
                        end
                    end
                    shs_pkg::PH_LENLO: begin
                        o_cmd.push_word = r_bitlen[31:0];
                        n_phase = shs_pkg::PH_DONE;
                    end
                    default: o_cmd.push = 1'b0;
                endcase
            end
            shs_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 1'b1;
            end
            shs_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            shs_pkg::ST_EMIT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_idx      = r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        // start a fresh message
                        o_cmd.reset_chain = 1'b1;
                        n_bitlen = '0;
                        n_fin    = 1'b0;
                        n_phase  = shs_pkg::PH_ZERO;
                    end
                end
            end
            default: ;
        endcase
        if (o_cmd.push) begin
            n_fill     = r_fill + 1'b1;
            o_cmd.load = (r_fill == FILL_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= shs_pkg::ST_IDLE;
            r_phase  <= shs_pkg::PH_ZERO;
            r_fill   <= '0;
            r_bitlen <= '0;
            r_fin    <= 1'b0;
            r_round  <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
            r_fin    <= n_fin;
            r_round  <= n_round;
            r_idx    <= n_idx;
        end
    end

    // round counter only runs during compression
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != shs_pkg::ST_ROUND |-> r_round == '0)
        else $error("round counter not at zero outside compression");

    // compression starts only on a full buffer
    a_round_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shs_pkg::ST_ROUND && $past(r_state) != shs_pkg::ST_ROUND)
            |-> r_fill == '0)
        else $error("compression entered with partial block");

    // digest only leaves after the length words went in
    a_emit_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == shs_pkg::ST_EMIT |-> (r_fill == '0 && r_phase == shs_pkg::PH_DONE))
        else $error("digest output with padding incomplete");

endmodule

// ===== rtl/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 of a word stream; digest leaves as eight 32-bit words, MSW first
// a non-final request is taken while the sequencer is idle; each 16th word adds
//   a full compression plus one chaining update (round unit bound)
// a final request adds its padding words, one or two compressions, then
//   eight digest words at one per cycle when the sink is ready
// synchronous active-low reset loads the initial hash values and clears
//   fill count, bit count and the output valid flag; no clearing pass
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [shs_pkg::WORD_W-1:0]    i_data_word,
    input  logic [shs_pkg::CNT_W-1:0]     i_byte_count,
    input  logic                          i_final_req,
    // digest channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [shs_pkg::WORD_W-1:0]    o_digest_word,
    output logic [shs_pkg::IDX_W-1:0]     o_word_index,
    output logic                          o_last_word
);

    localparam logic [shs_pkg::IDX_W-1:0] IDX_LAST = shs_pkg::IDX_W'(shs_pkg::DIGEST_WORDS - 1);

    shs_pkg::t_core_cmd               cmd;
    logic [shs_pkg::WORD_W-1:0]       chain_word;
    logic                             out_free;

    // output register: slot free when empty or being drained this cycle
    logic                             r_out_valid;
    logic [shs_pkg::WORD_W-1:0]       r_digest_word;
    logic [shs_pkg::IDX_W-1:0]        r_word_index;
    logic                             r_last_word;

    assign out_free = !r_out_valid || i_ready;

    // sequencer: request handshake, padding, round count, digest stepping
    shs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_final_req  (i_final_req),
        .i_out_free   (out_free),
        .o_cmd        (cmd)
    );

    // shared round unit with block buffer and chaining words
    shs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_digest_word (chain_word)
    );

    // valid flag is control state, payload loads without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_digest_word <= chain_word;
            r_word_index  <= cmd.idx;
            r_last_word   <= (cmd.idx == IDX_LAST);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_digest_word = r_digest_word;
    assign o_word_index  = r_word_index;
    assign o_last_word   = r_last_word;

    // a digest word is only produced into a free slot
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> out_free)
        else $error("digest word overwrote a pending result");

    // no new request is taken while a digest is being stepped out
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !o_ready)
        else $error("request taken during digest output");

    // the final digest word carries index seven
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word) |-> o_word_index == IDX_LAST)
        else $error("last word flag on wrong index");

endmodule

// ===== tb/sha256_stream_hasher_top_test.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top_test
// Self-checking bench for the SHA-256 stream hasher: a short table of
// directed requests (empty message, "abc", byte count extremes, padding that
// spills into a second block) then random messages of varied length under
// four idling phases and one long digest hold-off; every digest word is
// compared with a known digest or an in-bench SHA-256 model
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top_test;

    localparam int WORD_W = shs_pkg::WORD_W;
    localparam int CNT_W  = shs_pkg::CNT_W;
    localparam int IDX_W  = shs_pkg::IDX_W;

    // run limits
    localparam int RANDOM_ITEMS   = 240;
    localparam int HOLD_CYCLES    = 500;  // long digest hold-off, forces input stall
    localparam int DRAIN_CYCLES   = 200;  // > two compressions plus padding
    localparam int WATCHDOG_LIMIT = 4000; // cycles without any transfer

    // padding constants
    localparam logic [WORD_W-1:0] END_MARK  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MARK_BYTE = 32'h0000_0080;
    localparam int                MAX_BYTES = 4;
    localparam int                LEN_SLOT  = 14; // first of the two length words

    // digest words of two well-known messages
    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] DIGEST_ABC =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [WORD_W-1:0] START_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one digest word as it should leave the block
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  pos;
        logic              last;
    } t_digest_word;

    // one row of the directed table; known_digest used only where has_known
    typedef struct {
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  nbytes;
        logic              fin;
        bit                has_known;
        logic [255:0]      known_digest;
    } t_request_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [WORD_W-1:0] i_data_word;
    logic [CNT_W-1:0]  i_byte_count;
    logic              i_final_req;
    logic              o_valid;
    logic              i_ready;
    logic [WORD_W-1:0] o_digest_word;
    logic [IDX_W-1:0]  o_word_index;
    logic              o_last_word;

    // in-bench hash state
    logic [WORD_W-1:0] chain_words  [8];
    logic [WORD_W-1:0] buffer_words [16];
    int                fill_count;
    logic [63:0]       msg_bits;

    t_digest_word digest_q [$];  // digest words still owed by the block
    int           error_count;
    int           stall_cycles;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_pending;
    int           hold_left;

    // directed requests: each final row closes a message
    t_request_row directed_rows [25] = '{
        // empty message straight after reset
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1, DIGEST_EMPTY},
        // "abc" with junk in the unused low byte, which must be dropped
        '{32'h6162_63a5, 3'd3, 1'b1, 1'b1, DIGEST_ABC},
        // byte count ignored on a non-final word, above four on the final
        '{32'hffff_ffff, 3'd0, 1'b0, 1'b0, '0},
        '{32'hffff_ffff, 3'd7, 1'b1, 1'b0, '0},
        '{32'h0000_0000, 3'd7, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 3'd5, 1'b1, 1'b0, '0},
        '{32'h1234_5678, 3'd3, 1'b0, 1'b0, '0},
        '{32'hdead_beef, 3'd6, 1'b1, 1'b0, '0},
        // single byte with garbage below it, then a full final word
        '{32'hcafe_f00d, 3'd1, 1'b1, 1'b0, '0},
        '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0},
        // fourteen words then an empty final: the end mark lands in the
        // length slot, so the length goes into a second block
        '{32'h0102_0304, 3'd4, 1'b0, 1'b0, '0}, '{32'hffff_0000, 3'd4, 1'b0, 1'b0, '0},
        '{32'h8000_0001, 3'd2, 1'b0, 1'b0, '0}, '{32'h7fff_fffe, 3'd1, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 3'd4, 1'b0, 1'b0, '0}, '{32'haaaa_aaaa, 3'd6, 1'b0, 1'b0, '0},
        '{32'h0000_ffff, 3'd4, 1'b0, 1'b0, '0}, '{32'h0f0f_0f0f, 3'd0, 1'b0, 1'b0, '0},
        '{32'hf0f0_f0f0, 3'd4, 1'b0, 1'b0, '0}, '{32'h3333_cccc, 3'd3, 1'b0, 1'b0, '0},
        '{32'h6a09_e667, 3'd4, 1'b0, 1'b0, '0}, '{32'h0000_0001, 3'd7, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 3'd4, 1'b0, 1'b0, '0}, '{32'hffff_fffe, 3'd5, 1'b0, 1'b0, '0},
        '{32'h9abc_def0, 3'd0, 1'b1, 1'b0, '0}
    };

    sha256_stream_hasher_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_final_req  (i_final_req),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digest_word(o_digest_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

    // 4 unit clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // hash model
    // ------------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int s);
        return (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic void start_message();
        chain_words = START_CHAIN;
        fill_count  = 0;
        msg_bits    = '0;
    endfunction

    // 64 rounds over the full block buffer, folded into the chain
    function automatic void compress_buffer();
        logic [WORD_W-1:0] sched [64];
        logic [WORD_W-1:0] a, b, c, d, e, f, g, h;
        logic [WORD_W-1:0] t1, t2, lo0, lo1;
        for (int t = 0; t < 16; t++) sched[t] = buffer_words[t];
        for (int t = 16; t < 64; t++) begin
            lo0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
            lo1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sched[t-16] + lo0 + sched[t-7] + lo1;
        end
        {a, b, c, d, e, f, g, h} = {chain_words[0], chain_words[1], chain_words[2],
                                    chain_words[3], chain_words[4], chain_words[5],
                                    chain_words[6], chain_words[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[t] + sched[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
        chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
    endfunction

    function automatic void load_word(input logic [WORD_W-1:0] w);
        buffer_words[fill_count] = w;
        fill_count = (fill_count + 1) % 16;
        if (fill_count == 0) compress_buffer();
    endfunction

    // takes one request; on a final one pads, finishes and returns the digest
    function automatic bit hash_request(input logic [WORD_W-1:0] data,
                                        input logic [CNT_W-1:0] nbytes,
                                        input logic fin,
                                        output logic [255:0] digest);
        int                nb;
        logic [WORD_W-1:0] keep;
        digest = '0;
        if (!fin) begin
            msg_bits += 64'd32;
            load_word(data);
            return 1'b0;
        end
        nb = (nbytes > MAX_BYTES) ? MAX_BYTES : int'(nbytes);
        msg_bits += 64'(8 * nb);
        if (nb == MAX_BYTES) begin
            load_word(data);
            load_word(END_MARK);
        end else begin
            keep = (nb == 0) ? '0 : ({WORD_W{1'b1}} << (WORD_W - 8 * nb));
            load_word((data & keep) | (MARK_BYTE << (24 - 8 * nb)));
        end
        // no room left for the length: zero out this block first
        if (fill_count > LEN_SLOT) load_word('0);
        while (fill_count != LEN_SLOT) load_word('0);
        load_word(msg_bits[63:32]);
        load_word(msg_bits[31:0]);
        for (int j = 0; j < 8; j++) digest[255 - 32*j -: 32] = chain_words[j];
        start_message();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // entered and left at a falling edge; queues eight digest words on a final
    task automatic send_request(input logic [WORD_W-1:0] data,
                                input logic [CNT_W-1:0] nbytes,
                                input logic fin,
                                input bit has_known,
                                input logic [255:0] known_digest);
        logic [255:0] digest;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_word  <= data;
        i_byte_count <= nbytes;
        i_final_req  <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (hash_request(data, nbytes, fin, digest)) begin
            if (has_known) digest = known_digest;
            for (int j = 0; j < 8; j++)
                digest_q.push_back('{digest[255 - 32*j -: 32], IDX_W'(j), j == 7});
        end
        @(negedge i_clk);
    endtask

    // random message; lengths cluster around the padding corners of a block
    task automatic send_random_message(output int n_items);
        int words;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            words = $urandom_range(0, 16);
        else if (pick < 9)
            words = $urandom_range(12, 15) + 16 * $urandom_range(0, 1);
        else
            words = $urandom_range(17, 40);
        for (int k = 0; k < words; k++)
            send_request($urandom, CNT_W'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
        send_request($urandom, CNT_W'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
        n_items = words + 1;
    endtask

    // ------------------------------------------------------------------------
    // digest side
    // ------------------------------------------------------------------------

    // ready drawn at each falling edge; a pending hold-off keeps it low for
    // a long stretch so the block backs up into its request port
    always @(negedge i_clk) begin
        if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // every digest word against the oldest owed one
    always @(posedge i_clk) begin : digest_check
        t_digest_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected digest word %h index %0d last %b",
                         $time, o_digest_word, o_word_index, o_last_word);
            end else begin
                want = digest_q.pop_front();
                if (o_digest_word !== want.word) begin
                    error_count++;
                    $display("%0t: digest word %0d expected %h actual %h",
                             $time, want.pos, want.word, o_digest_word);
                end
                if (o_word_index !== want.pos) begin
                    error_count++;
                    $display("%0t: word index expected %0d actual %0d",
                             $time, want.pos, o_word_index);
                end
                if (o_last_word !== want.last) begin
                    error_count++;
                    $display("%0t: last word flag at index %0d expected %b actual %b",
                             $time, want.pos, want.last, o_last_word);
                end
            end
        end
    end

    // watchdog: too long with neither channel moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[sha256_stream_hasher_top] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin : main_seq
        int phase_items;
        int n_items;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_word    = '0;
        i_byte_count   = '0;
        i_final_req    = 1'b0;
        i_ready        = 1'b0;
        error_count    = 0;
        stall_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b0;
        hold_left      = 0;
        start_message();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (directed_rows[r])
            send_request(directed_rows[r].data, directed_rows[r].nbytes,
                         directed_rows[r].fin, directed_rows[r].has_known,
                         directed_rows[r].known_digest);

        // random messages: flat out (with the hold-off), sender idling,
        // receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            if (phase == 0) hold_pending = 1'b1;
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 4) begin
                send_random_message(n_items);
                phase_items += n_items;
            end
        end

        // drain: every owed word out, then watch for strays
        i_valid        <= 1'b0;
        recv_stall_pct  = 0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("[sha256_stream_hasher_top] OK");
        else
            $display("[sha256_stream_hasher_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/shs_pkg.sv
rtl/shs_core.sv
rtl/shs_ctrl.sv
rtl/sha256_stream_hasher_top.sv
tb/sha256_stream_hasher_top_test.sv
